// ===== hw/rtl/grce_pkg.sv =====
// glyph row colour expander: shared types, codes and constants
// used by every module of the block; depends on nothing

package grce_pkg;

	localparam int FONT_ROWS       = 16;
	localparam bit SWAP_FONT_BYTES = 1'b0;

	localparam int ADDR_W = 5;

	// pixel formats
	localparam logic [2:0] FMT_1BIT    = 3'd0;
	localparam logic [2:0] FMT_2BIT    = 3'd1;
	localparam logic [2:0] FMT_4BIT    = 3'd2;
	localparam logic [2:0] FMT_RGB332  = 3'd3;
	localparam logic [2:0] FMT_RGB555  = 3'd4;
	localparam logic [2:0] FMT_RGB565  = 3'd5;
	localparam logic [2:0] FMT_RGB888  = 3'd6;
	localparam logic [2:0] FMT_RGBX888 = 3'd7;

	// write sizes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	// register indexes
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [2:0] REG_LINE_STRIDE  = 3'd1;
	localparam logic [2:0] REG_BACK_A       = 3'd2;
	localparam logic [2:0] REG_FORE_A       = 3'd3;
	localparam logic [2:0] REG_BACK_B       = 3'd4;
	localparam logic [2:0] REG_FORE_B       = 3'd5;
	localparam logic [2:0] REG_BACK_C       = 3'd6;
	localparam logic [2:0] REG_FORE_C       = 3'd7;

	localparam logic [2:0]  FMT_RESET = FMT_RGB332;

	typedef struct packed {
		logic [7:0]  glyph_bits;
		logic [3:0]  glyph_line;
		logic [11:0] cell_x;
		logic [11:0] cell_y;
	} row_in_t;

	typedef struct packed {
		logic [26:0] byte_offset;
		logic [31:0] write_data;
		logic [1:0]  write_size;
		logic        last_write;
	} wr_out_t;

	typedef struct packed {
		logic [2:0]  pixel_format;
		logic [13:0] line_stride;
		logic [31:0] back_a;
		logic [31:0] fore_a;
		logic [31:0] back_b;
		logic [31:0] fore_b;
		logic [31:0] back_c;
		logic [31:0] fore_c;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  bits;
		logic [26:0] base;
		logic [2:0]  idx;
		logic        last;
	} write_req_t;

	function automatic logic [2:0] last_idx(input logic [2:0] fmt);
		logic [2:0] r;
		case (fmt)
			FMT_1BIT:    r = 3'd0;
			FMT_2BIT:    r = 3'd1;
			FMT_4BIT:    r = 3'd1;
			FMT_RGB332:  r = 3'd1;
			FMT_RGB555:  r = 3'd3;
			FMT_RGB565:  r = 3'd3;
			FMT_RGB888:  r = 3'd5;
			default:     r = 3'd7;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/grce_regs.sv =====
// glyph row colour expander: configuration registers behind the apb port
// depends on grce_pkg

module grce_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grce_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output grce_pkg::cfg_t              cfg
);

	grce_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= grce_pkg::FMT_RESET;
			cfg_q.line_stride  <= '0;
			cfg_q.back_a       <= '0;
			cfg_q.fore_a       <= '0;
			cfg_q.back_b       <= '0;
			cfg_q.fore_b       <= '0;
			cfg_q.back_c       <= '0;
			cfg_q.fore_c       <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				grce_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= pwdata[2:0];
				grce_pkg::REG_LINE_STRIDE:  cfg_q.line_stride  <= pwdata[13:0];
				grce_pkg::REG_BACK_A:       cfg_q.back_a       <= pwdata;
				grce_pkg::REG_FORE_A:       cfg_q.fore_a       <= pwdata;
				grce_pkg::REG_BACK_B:       cfg_q.back_b       <= pwdata;
				grce_pkg::REG_FORE_B:       cfg_q.fore_b       <= pwdata;
				grce_pkg::REG_BACK_C:       cfg_q.back_c       <= pwdata;
				grce_pkg::REG_FORE_C:       cfg_q.fore_c       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			grce_pkg::REG_PIXEL_FORMAT: prdata = {29'd0, cfg_q.pixel_format};
			grce_pkg::REG_LINE_STRIDE:  prdata = {18'd0, cfg_q.line_stride};
			grce_pkg::REG_BACK_A:       prdata = cfg_q.back_a;
			grce_pkg::REG_FORE_A:       prdata = cfg_q.fore_a;
			grce_pkg::REG_BACK_B:       prdata = cfg_q.back_b;
			grce_pkg::REG_FORE_B:       prdata = cfg_q.fore_b;
			grce_pkg::REG_BACK_C:       prdata = cfg_q.back_c;
			grce_pkg::REG_FORE_C:       prdata = cfg_q.fore_c;
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/grce_in_stage.sv =====
// glyph row colour expander: input register, row base offset and write index
// depends on grce_pkg

module grce_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grce_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  grce_pkg::row_in_t    item,
	output logic                 req_valid,
	input  logic                 req_ready,
	output grce_pkg::write_req_t req
);

	logic        valid_s1;
	logic [2:0]  idx_s1;
	logic [7:0]  bits_s1;
	logic [26:0] base_s1;
	logic        line_ok;
	logic        load;
	logic        advance;
	logic        last;
	logic [12:0] row;
	logic [26:0] row_off;
	logic [13:0] x_off;
	logic [26:0] base;

	assign last       = idx_s1 == grce_pkg::last_idx(cfg.pixel_format);
	assign advance    = valid_s1 && req_ready;
	assign item_stall = valid_s1 && !(advance && last);
	assign line_ok    = {2'b00, item.glyph_line} < 6'(grce_pkg::FONT_ROWS);
	assign load       = item_valid && !item_stall && line_ok;

	assign row     = 13'(item.cell_y) + 13'(item.glyph_line);
	assign row_off = 27'(cfg.line_stride) * 27'(row);

	always_comb begin
		case (cfg.pixel_format)
			grce_pkg::FMT_1BIT:   x_off = 14'(item.cell_x[11:3]);
			grce_pkg::FMT_2BIT:   x_off = 14'(item.cell_x[11:2]);
			grce_pkg::FMT_4BIT:   x_off = 14'(item.cell_x[11:1]);
			grce_pkg::FMT_RGB332: x_off = 14'(item.cell_x);
			grce_pkg::FMT_RGB555: x_off = {1'b0, item.cell_x, 1'b0};
			grce_pkg::FMT_RGB565: x_off = {1'b0, item.cell_x, 1'b0};
			grce_pkg::FMT_RGB888: x_off = 14'(item.cell_x) + {1'b0, item.cell_x, 1'b0};
			default:              x_off = {item.cell_x, 2'b00};
		endcase
	end

	assign base = row_off + 27'(x_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (advance && last) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (advance) begin
			idx_s1   <= idx_s1 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_s1 <= item.glyph_bits;
			base_s1 <= base;
		end
	end

	assign req_valid = valid_s1;
	assign req.bits  = bits_s1;
	assign req.base  = base_s1;
	assign req.idx   = idx_s1;
	assign req.last  = last;

endmodule

// ===== hw/rtl/grce_out_stage.sv =====
// glyph row colour expander: colour expansion of one write and result register
// depends on grce_pkg

module grce_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grce_pkg::cfg_t       cfg,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  grce_pkg::write_req_t req,
	output logic                 wr_valid,
	input  logic                 wr_stall,
	output grce_pkg::wr_out_t    wr
);

	logic              valid_s2;
	grce_pkg::wr_out_t wr_s2;
	logic              advance;

	logic [3:0]  nib;
	logic [3:0]  nib24;
	logic [7:0]  shl_pair;
	logic [7:0]  shl_one;
	logic [15:0] fm16;
	logic [95:0] m96;
	logic        hi_group;
	logic [1:0]  lane;
	logic [31:0] mask;
	logic [31:0] bg;
	logic [31:0] fg;
	logic [31:0] raw;
	logic [31:0] data;
	logic [1:0]  size;
	logic [26:0] step;

	function automatic logic [31:0] swap_bytes32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	assign nib      = req.idx[0] ? req.bits[3:0] : req.bits[7:4];
	assign hi_group = req.idx >= 3'd3;
	assign nib24    = hi_group ? req.bits[3:0] : req.bits[7:4];
	assign shl_pair = req.bits << {req.idx[1:0], 1'b0};
	assign shl_one  = req.bits << req.idx;
	assign fm16     = (cfg.pixel_format == grce_pkg::FMT_RGB555) ? 16'h7fff : 16'hffff;
	assign m96      = {{24{nib24[3]}}, {24{nib24[2]}}, {24{nib24[1]}}, {24{nib24[0]}}};

	always_comb begin
		mask = '0;
		lane = 2'd0;
		size = grce_pkg::SIZE_WORD;
		step = {22'd0, req.idx, 2'b00};
		case (cfg.pixel_format)
			grce_pkg::FMT_1BIT: begin
				mask = {24'd0, req.bits};
				size = grce_pkg::SIZE_BYTE;
				step = '0;
			end
			grce_pkg::FMT_2BIT: begin
				for (int j = 0; j < 4; j++) mask[2*j +: 2] = {2{nib[j]}};
				size = grce_pkg::SIZE_BYTE;
				step = 27'(req.idx);
			end
			grce_pkg::FMT_4BIT: begin
				for (int j = 0; j < 4; j++) mask[4*j +: 4] = {4{nib[j]}};
				size = grce_pkg::SIZE_HALF;
				step = {23'd0, req.idx, 1'b0};
			end
			grce_pkg::FMT_RGB332: begin
				for (int j = 0; j < 4; j++) mask[8*j +: 8] = {8{nib[j]}};
			end
			grce_pkg::FMT_RGB555, grce_pkg::FMT_RGB565: begin
				mask = {(shl_pair[7] ? fm16 : 16'h0000), (shl_pair[6] ? fm16 : 16'h0000)};
			end
			grce_pkg::FMT_RGB888: begin
				lane = hi_group ? 2'(req.idx - 3'd3) : req.idx[1:0];
				case (lane)
					2'd0:    mask = m96[95:64];
					2'd1:    mask = m96[63:32];
					default: mask = m96[31:0];
				endcase
			end
			default: begin
				mask = shl_one[7] ? 32'h00ffffff : 32'h00000000;
			end
		endcase
	end

	always_comb begin
		case (lane)
			2'd1: begin
				bg = cfg.back_b;
				fg = cfg.fore_b;
			end
			2'd2: begin
				bg = cfg.back_c;
				fg = cfg.fore_c;
			end
			default: begin
				bg = cfg.back_a;
				fg = cfg.fore_a;
			end
		endcase
	end

	assign raw = (mask & (bg ^ fg)) ^ bg;

	always_comb begin
		case (cfg.pixel_format)
			grce_pkg::FMT_1BIT, grce_pkg::FMT_2BIT: data = {24'd0, raw[7:0]};
			grce_pkg::FMT_4BIT:
				data = grce_pkg::SWAP_FONT_BYTES ? {16'd0, raw[7:0], raw[15:8]}
				                                 : {16'd0, raw[15:0]};
			grce_pkg::FMT_RGB332, grce_pkg::FMT_RGB888:
				data = grce_pkg::SWAP_FONT_BYTES ? swap_bytes32(raw) : raw;
			grce_pkg::FMT_RGB555, grce_pkg::FMT_RGB565:
				data = grce_pkg::SWAP_FONT_BYTES ? {raw[15:0], raw[31:16]} : raw;
			default: data = raw;
		endcase
	end

	assign req_ready = !valid_s2 || !wr_stall;
	assign advance   = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (req_ready) begin
			valid_s2 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wr_s2.byte_offset <= req.base + step;
			wr_s2.write_data  <= data;
			wr_s2.write_size  <= size;
			wr_s2.last_write  <= req.last;
		end
	end

	assign wr_valid = valid_s2;
	assign wr       = wr_s2;

endmodule

// ===== hw/rtl/glyph_row_color_expander_core.sv =====
// glyph row colour expander: top level joining registers, input stage and
// output stage; depends on grce_pkg, grce_regs, grce_in_stage, grce_out_stage
//
// usage:
//  - item channel (item_valid, item_stall, item) carries one glyph row with
//    its cell position and row number; a transfer takes place when valid is
//    high and stall is low
//  - wr channel (wr_valid, wr_stall, wr) carries the framebuffer writes of
//    each row, left pixels first, last_write set on the final one
//  - a row gives 1, 2, 4, 6 or 8 writes by pixel format, one per cycle while
//    the receiver does not stall; a new row is taken in the cycle its
//    predecessor's last write leaves the input register
//  - the first write of a row is registered in the input register, then in
//    the result register, from which it leaves on the wr channel
//  - a row whose line lies beyond the font is taken and gives no write
//  - while the receiver stalls, the pending write holds and item_stall stays
//    high while the input register holds a row
//  - the apb port writes registers in its access cycle, pready always high;
//    configuration must be written only while no row is in flight (unenforced)
//  - reset clears all registers (pixel format to rgb332) and both stages

module glyph_row_color_expander_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  grce_pkg::row_in_t           item,
	output logic                        wr_valid,
	input  logic                        wr_stall,
	output grce_pkg::wr_out_t           wr,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [grce_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	grce_pkg::cfg_t       cfg;
	grce_pkg::write_req_t req;
	logic                 req_valid;
	logic                 req_ready;

	grce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	grce_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req)
	);

	grce_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr        (wr)
	);

	// empty input register never holds off a row
	a_stall_needs_row: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> req_valid)
		else $error("item stalled with empty input register");

	// a write taken with nothing behind it empties the result register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && !wr_stall && !req_valid) |=> !wr_valid)
		else $error("result register kept a write already transferred");

	// a free result register always draws the pending write
	a_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !wr_valid) |=> wr_valid)
		else $error("pending write not moved into free result register");

endmodule
